// ===== src/fpb_pkg.sv =====
// ----------------------------------------------------------------------------
// fpb_pkg
// Types, constants and small helper functions shared by the frustum plane
// builder and sphere test.
// ----------------------------------------------------------------------------
package fpb_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int NUM_CORNERS = 8;
  localparam int CNT_W       = 5;

  localparam logic [2:0] LAST_CORNER = 3'd7;
  localparam logic [2:0] LAST_PLANE  = 3'd5;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LDA, ST_LDU, ST_LDV, ST_CROSS, ST_NORM, ST_SQ, ST_SQRT_INIT,
    ST_SQRT, ST_CHK, ST_DIV_INIT, ST_DIV, ST_QSTORE, ST_DOT, ST_PWRITE,
    ST_TMAC, ST_TCMP, ST_TOUT
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LOAD, DP_TLATCH, DP_LDA, DP_LDU, DP_LDV, DP_CROSS, DP_NORM,
    DP_SQ, DP_SQRT_INIT, DP_SQRT, DP_DIV_INIT, DP_DIV, DP_QSTORE, DP_DOT,
    DP_PWRITE, DP_TMAC, DP_TCMP, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       comp;
    logic [2:0]       k;
  } dp_cmd_t;

  typedef struct packed {
    logic len_zero;
  } dp_stat_t;

  // Clamp a signed 64-bit value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Corner triple (a,b,c) of each plane.
  function automatic logic [2:0] tri_corner(input logic [2:0] k, input logic [1:0] sel);
    logic [8:0] row;
    logic [2:0] r;
    unique case (k)
      3'd0:    row = {3'd1, 3'd5, 3'd6};
      3'd1:    row = {3'd4, 3'd0, 3'd3};
      3'd2:    row = {3'd4, 3'd5, 3'd1};
      3'd3:    row = {3'd3, 3'd2, 3'd6};
      3'd4:    row = {3'd5, 3'd4, 3'd7};
      default: row = {3'd0, 3'd1, 3'd2};
    endcase
    unique case (sel)
      2'd0:    r = row[8:6];
      2'd1:    r = row[5:3];
      default: r = row[2:0];
    endcase
    return r;
  endfunction

endpackage

// ===== src/fpb_ctrl.sv =====
// ----------------------------------------------------------------------------
// fpb_ctrl
// Sequencer that steps the datapath through plane builds and point tests.
// ----------------------------------------------------------------------------
module fpb_ctrl import fpb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       mode,
  input  logic [2:0] corner_index,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_stat_t   stat
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [1:0]       comp, comp_next;
  logic [2:0]       k, k_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      comp      <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      comp      <= comp_next;
      k         <= k_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    comp_next      = comp;
    k_next         = k;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    cmd.op         = DP_NOP;
    cmd.cnt        = cnt;
    cmd.comp       = comp;
    cmd.k          = k;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          k_next   = '0;
          cnt_next = '0;
          if (!mode) begin
            cmd.op = DP_LOAD;
            if (corner_index == LAST_CORNER) begin
              state_next = ST_LDA;
            end
          end else begin
            cmd.op     = DP_TLATCH;
            state_next = ST_TMAC;
          end
        end
      end
      ST_LDA: begin
        cmd.op     = DP_LDA;
        state_next = ST_LDU;
      end
      ST_LDU: begin
        cmd.op     = DP_LDU;
        state_next = ST_LDV;
      end
      ST_LDV: begin
        cmd.op     = DP_LDV;
        cnt_next   = '0;
        state_next = ST_CROSS;
      end
      ST_CROSS: begin
        cmd.op = DP_CROSS;
        if (cnt == CNT_W'(6)) begin
          state_next = ST_NORM;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_NORM: begin
        cmd.op     = DP_NORM;
        cnt_next   = '0;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.op = DP_SQ;
        if (cnt == CNT_W'(3)) begin
          state_next = ST_SQRT_INIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_SQRT_INIT: begin
        cmd.op     = DP_SQRT_INIT;
        cnt_next   = '0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = DP_SQRT;
        if (cnt == CNT_W'(31)) begin
          state_next = ST_CHK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_CHK: begin
        comp_next  = '0;
        state_next = stat.len_zero ? ST_PWRITE : ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.op     = DP_DIV_INIT;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.op = DP_DIV;
        if (cnt == CNT_W'(FRAC_BITS)) begin
          state_next = ST_QSTORE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_QSTORE: begin
        cmd.op = DP_QSTORE;
        if (comp == 2'd2) begin
          cnt_next   = '0;
          state_next = ST_DOT;
        end else begin
          comp_next  = comp + 1'b1;
          state_next = ST_DIV_INIT;
        end
      end
      ST_DOT: begin
        cmd.op = DP_DOT;
        if (cnt == CNT_W'(3)) begin
          state_next = ST_PWRITE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_PWRITE: begin
        cmd.op = DP_PWRITE;
        if (k == LAST_PLANE) begin
          state_next = ST_IDLE;
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_LDA;
        end
      end
      ST_TMAC: begin
        cmd.op = DP_TMAC;
        if (cnt == CNT_W'(3)) begin
          state_next = ST_TCMP;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_TCMP: begin
        cmd.op   = DP_TCMP;
        cnt_next = '0;
        if (k == LAST_PLANE) begin
          state_next = ST_TOUT;
        end else begin
          k_next     = k + 1'b1;
          state_next = ST_TMAC;
        end
      end
      ST_TOUT: begin
        if (!out_valid || out_ready) begin
          cmd.op         = DP_OUT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_build_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !mode && corner_index == LAST_CORNER) |=> state == ST_LDA)
    else $error("load of last corner did not start a plane build");
  a_test_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && mode) |=> (state == ST_TMAC && k == 3'd0))
    else $error("test request did not start at the first plane");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before it was taken");
  a_sqrt_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SQRT && cnt == CNT_W'(31)) |=> state == ST_CHK)
    else $error("square root did not finish after its last step");
`endif

endmodule

// ===== src/fpb_dp.sv =====
// ----------------------------------------------------------------------------
// fpb_dp
// Corner and plane storage, shared multiplier, square root and divider.
// ----------------------------------------------------------------------------
module fpb_dp import fpb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic [2:0]         corner_index,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic signed [31:0] radius,
  output logic               inside_res
);

  logic signed [31:0] cx [NUM_CORNERS];
  logic signed [31:0] cy [NUM_CORNERS];
  logic signed [31:0] cz [NUM_CORNERS];
  logic signed [31:0] pl [NUM_PLANES][4];

  logic signed [31:0] a [3];
  logic signed [31:0] u [3];
  logic signed [31:0] v [3];
  logic signed [31:0] n [3];
  logic signed [31:0] q [3];
  logic signed [31:0] p [3];
  logic signed [31:0] mq [6];
  logic signed [31:0] rad;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic [63:0]        sq_x, sq_res, sq_bit;
  logic [33:0]        div_r;
  logic [FRAC_BITS:0] quo;
  logic               all_in;

  logic [2:0]         csel;
  logic [1:0]         rsel;
  logic signed [31:0] rd [3];
  logic [1:0]         midx;
  logic [1:0]         psel;
  logic signed [31:0] pl_rd;
  logic signed [31:0] mul_a, mul_b;
  logic [63:0]        sq_t;
  logic [31:0]        len;
  logic [31:0]        mag;
  logic [33:0]        div_rr;
  logic               div_ge;
  logic signed [31:0] q_ext;
  logic signed [64:0] tsum;
  logic [2:0]         mq_wr;

  assign rsel = (cmd.op == DP_LDA) ? 2'd0 : (cmd.op == DP_LDU) ? 2'd1 : 2'd2;
  assign csel = tri_corner(cmd.k, rsel);
  assign rd[0] = cx[csel];
  assign rd[1] = cy[csel];
  assign rd[2] = cz[csel];

  assign midx  = (cmd.cnt[1:0] == 2'd3) ? 2'd2 : cmd.cnt[1:0];
  assign psel  = (cmd.op == DP_TCMP) ? 2'd3 : midx;
  assign pl_rd = pl[cmd.k][psel];
  assign mq_wr = 3'(cmd.cnt - 1'b1);

  always_comb begin
    mul_a = u[1];
    mul_b = v[0];
    unique case (cmd.op)
      DP_CROSS: begin
        unique case (cmd.cnt[2:0])
          3'd0:    begin mul_a = u[1]; mul_b = v[2]; end
          3'd1:    begin mul_a = u[2]; mul_b = v[1]; end
          3'd2:    begin mul_a = u[2]; mul_b = v[0]; end
          3'd3:    begin mul_a = u[0]; mul_b = v[2]; end
          3'd4:    begin mul_a = u[0]; mul_b = v[1]; end
          default: begin mul_a = u[1]; mul_b = v[0]; end
        endcase
      end
      DP_SQ: begin
        mul_a = n[midx];
        mul_b = n[midx];
      end
      DP_DOT: begin
        mul_a = q[midx];
        mul_b = a[midx];
      end
      DP_TMAC: begin
        mul_a = pl_rd;
        mul_b = p[midx];
      end
      default: ;
    endcase
  end

  assign sq_t   = sq_res + sq_bit;
  assign len    = sq_res[31:0];
  assign mag    = n[cmd.comp][31] ? 32'(-n[cmd.comp]) : 32'(n[cmd.comp]);
  assign div_rr = (cmd.cnt == '0) ? div_r : {div_r[32:0], 1'b0};
  assign div_ge = div_rr >= {2'b00, len};
  assign q_ext  = {{(31 - FRAC_BITS){1'b0}}, quo};
  assign tsum   = 65'(acc >>> FRAC_BITS) + 65'(pl_rd);
  assign stat.len_zero = (sq_res == '0);

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (cmd.op)
      DP_LOAD: begin
        cx[corner_index] <= coord_x;
        cy[corner_index] <= coord_y;
        cz[corner_index] <= coord_z;
      end
      DP_TLATCH: begin
        p[0]   <= coord_x;
        p[1]   <= coord_y;
        p[2]   <= coord_z;
        rad    <= radius;
        all_in <= 1'b1;
      end
      DP_LDA: begin
        for (int i = 0; i < 3; i++) a[i] <= rd[i];
      end
      DP_LDU: begin
        for (int i = 0; i < 3; i++) u[i] <= sat32(64'(rd[i]) - 64'(a[i]));
      end
      DP_LDV: begin
        for (int i = 0; i < 3; i++) v[i] <= sat32(64'(rd[i]) - 64'(a[i]));
      end
      DP_CROSS: begin
        if (cmd.cnt != '0) mq[mq_wr] <= sat32(prod >>> FRAC_BITS);
      end
      DP_NORM: begin
        for (int i = 0; i < 3; i++) n[i] <= sat32(64'(mq[2*i]) - 64'(mq[2*i+1]));
      end
      DP_SQ, DP_DOT, DP_TMAC: begin
        acc <= (cmd.cnt == '0) ? 64'sd0 : acc + prod;
      end
      DP_SQRT_INIT: begin
        sq_x   <= acc;
        sq_res <= '0;
        sq_bit <= 64'h4000_0000_0000_0000;
      end
      DP_SQRT: begin
        if (sq_x >= sq_t) begin
          sq_x   <= sq_x - sq_t;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      DP_DIV_INIT: begin
        div_r <= {2'b00, mag};
        quo   <= '0;
      end
      DP_DIV: begin
        div_r <= div_ge ? div_rr - {2'b00, len} : div_rr;
        quo   <= {quo[FRAC_BITS-1:0], div_ge};
      end
      DP_QSTORE: begin
        q[cmd.comp] <= n[cmd.comp][31] ? -q_ext : q_ext;
      end
      DP_TCMP: begin
        if (tsum > 65'(rad)) all_in <= 1'b0;
      end
      DP_OUT: begin
        inside_res <= all_in;
      end
      default: ;
    endcase
  end

  // Plane store resets to zero, so a test before any build sees zero planes.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_PLANES; k++) begin
        for (int j = 0; j < 4; j++) pl[k][j] <= '0;
      end
    end else if (cmd.op == DP_PWRITE) begin
      if (sq_res == '0) begin
        for (int j = 0; j < 4; j++) pl[cmd.k][j] <= '0;
      end else begin
        for (int j = 0; j < 3; j++) pl[cmd.k][j] <= q[j];
        pl[cmd.k][3] <= sat32(-(acc >>> FRAC_BITS));
      end
    end
  end

endmodule

// ===== src/frustum_plane_build_and_sphere_test.sv =====
// ----------------------------------------------------------------------------
// frustum_plane_build_and_sphere_test
// Builds six frustum planes from eight loaded corners and tests points with
// a radius against them, all in signed fixed point.
// ----------------------------------------------------------------------------
// A corner load is taken only while the sequencer is idle; loading corner 7
// then starts a plane build that runs, for each plane, the 32-step square
// root and, where the normal length is nonzero, the bit-per-cycle divider.
// A test runs six planes, each a multiply-accumulate and a compare, then
// loads the output register; no new request is taken until it is done.
// Synchronous reset clears the sequencer, the output flag and all planes.
// ----------------------------------------------------------------------------
module frustum_plane_build_and_sphere_test import fpb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               mode,
  input  logic [2:0]         corner_index,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic signed [31:0] radius,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               inside_res
);

  // The sequencer accepts a request only while idle. A finished result sits
  // in the output register; a new request may be taken while it waits, and
  // a later test holds in its final state until that register is free.
  dp_cmd_t  cmd;
  dp_stat_t stat;

  fpb_ctrl #(
    .FRAC_BITS(FRAC_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .mode        (mode),
    .corner_index(corner_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cmd         (cmd),
    .stat        (stat)
  );

  // The datapath holds the corners and planes and performs every multiply,
  // the square root of the squared normal length and the normalizing divide.
  fpb_dp #(
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .corner_index(corner_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .coord_z     (coord_z),
    .radius      (radius),
    .inside_res  (inside_res)
  );

endmodule
